// ===== src/gbnms_pkg.sv =====
package gbnms_pkg;

  // default sizes
  localparam int MAX_KEPT_DEF  = 64;
  localparam int MAX_ITEMS_DEF = 4096;

  // field widths
  localparam int COORD_W    = 15;
  localparam int LEN_W      = 14;
  localparam int AREA_W     = 28;
  localparam int SUM_W      = 29;
  localparam int THR_W      = 16;
  localparam int PROD_W     = 45;
  localparam int ITEM_IDX_W = 12;
  localparam int CNT_MAX_W  = 16;

  // one in Q0.16 plus headroom for the threshold add
  localparam logic [THR_W:0] THR_ONE = 17'h10000;
  localparam logic [THR_W-1:0] IOU_THR_RESET = 16'd29491;

  // configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic REG_IOU_THR = 1'b0;

  // transaction as it moves down the cell row
  typedef struct packed {
    logic                       vld;
    logic                       first;
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
    logic [LEN_W-1:0]           w;
    logic [LEN_W-1:0]           h;
    logic [AREA_W-1:0]          area;
    logic [ITEM_IDX_W-1:0]      idx;
    logic                       sup;
    logic                       stored;
  } box_pkt_t;

endpackage

// ===== src/gbnms_cell.sv =====
module gbnms_cell (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               adv,
  input  logic [gbnms_pkg::THR_W-1:0]        thr,
  input  gbnms_pkg::box_pkt_t                pkt_i,
  output gbnms_pkg::box_pkt_t                pkt_o
);

  // kept box held by this cell
  logic                                       occ_r;
  logic                                       occ_nxt;
  logic signed [gbnms_pkg::COORD_W-1:0]       kx_r;
  logic signed [gbnms_pkg::COORD_W-1:0]       ky_r;
  logic [gbnms_pkg::LEN_W-1:0]                kw_r;
  logic [gbnms_pkg::LEN_W-1:0]                kh_r;
  logic [gbnms_pkg::AREA_W-1:0]               karea_r;

  // stage 0: edges
  gbnms_pkg::box_pkt_t                        p0_r;
  gbnms_pkg::box_pkt_t                        p0_nxt;
  logic                                       cmp0_r;
  logic                                       cmp0_nxt;
  logic signed [gbnms_pkg::COORD_W:0]         lox0_r, hix0_r, loy0_r, hiy0_r;
  logic signed [gbnms_pkg::COORD_W:0]         lox0_nxt, hix0_nxt, loy0_nxt, hiy0_nxt;
  logic signed [gbnms_pkg::COORD_W:0]         ax_end, bx_end, ay_end, by_end;
  logic [gbnms_pkg::AREA_W-1:0]               karea0_r;

  // stage 1: overlap lengths and area sum
  gbnms_pkg::box_pkt_t                        p1_r;
  logic                                       cmp1_r;
  logic [gbnms_pkg::LEN_W-1:0]                ovx1_r, ovy1_r;
  logic [gbnms_pkg::LEN_W-1:0]                ovx1_nxt, ovy1_nxt;
  logic [gbnms_pkg::SUM_W-1:0]                sum1_r;
  logic [gbnms_pkg::SUM_W-1:0]                sum1_nxt;

  // stage 2: intersection and threshold times sum
  gbnms_pkg::box_pkt_t                        p2_r;
  logic                                       cmp2_r;
  logic [gbnms_pkg::AREA_W-1:0]               inter2_r;
  logic [gbnms_pkg::PROD_W-1:0]               ts2_r;

  // stage 3: intersection times (one plus threshold)
  gbnms_pkg::box_pkt_t                        p3_r;
  logic                                       cmp3_r;
  logic [gbnms_pkg::PROD_W-1:0]               li3_r;
  logic [gbnms_pkg::PROD_W-1:0]               ts3_r;

  // stage 4: compare
  gbnms_pkg::box_pkt_t                        p4_r;
  gbnms_pkg::box_pkt_t                        p4_nxt;

  logic occ_eff;
  logic live;
  logic store;

  always_comb begin
    occ_eff  = occ_r & ~pkt_i.first;
    live     = pkt_i.vld & ~pkt_i.sup & ~pkt_i.stored;
    store    = live & ~occ_eff;
    cmp0_nxt = live & occ_eff;
    occ_nxt  = pkt_i.vld ? (occ_eff | store) : occ_r;

    p0_nxt        = pkt_i;
    p0_nxt.stored = pkt_i.stored | store;

    ax_end   = (gbnms_pkg::COORD_W+1)'(pkt_i.x) + $signed({2'b00, pkt_i.w});
    bx_end   = (gbnms_pkg::COORD_W+1)'(kx_r) + $signed({2'b00, kw_r});
    ay_end   = (gbnms_pkg::COORD_W+1)'(pkt_i.y) + $signed({2'b00, pkt_i.h});
    by_end   = (gbnms_pkg::COORD_W+1)'(ky_r) + $signed({2'b00, kh_r});
    lox0_nxt = (pkt_i.x > kx_r) ? (gbnms_pkg::COORD_W+1)'(pkt_i.x)
                                : (gbnms_pkg::COORD_W+1)'(kx_r);
    loy0_nxt = (pkt_i.y > ky_r) ? (gbnms_pkg::COORD_W+1)'(pkt_i.y)
                                : (gbnms_pkg::COORD_W+1)'(ky_r);
    hix0_nxt = (ax_end < bx_end) ? ax_end : bx_end;
    hiy0_nxt = (ay_end < by_end) ? ay_end : by_end;

    // overlap never exceeds the shorter side, so it fits the length width
    ovx1_nxt = (hix0_r > lox0_r) ? gbnms_pkg::LEN_W'(hix0_r - lox0_r) : '0;
    ovy1_nxt = (hiy0_r > loy0_r) ? gbnms_pkg::LEN_W'(hiy0_r - loy0_r) : '0;
    sum1_nxt = gbnms_pkg::SUM_W'(p0_r.area) + gbnms_pkg::SUM_W'(karea0_r);

    // inter*65536 > thr*(sum-inter)  <=>  inter*(65536+thr) > thr*sum
    p4_nxt     = p3_r;
    p4_nxt.sup = p3_r.sup | (cmp3_r & (li3_r > ts3_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r  <= 1'b0;
      p0_r   <= '0;
      p1_r   <= '0;
      p2_r   <= '0;
      p3_r   <= '0;
      p4_r   <= '0;
      cmp0_r <= 1'b0;
      cmp1_r <= 1'b0;
      cmp2_r <= 1'b0;
      cmp3_r <= 1'b0;
    end else if (adv) begin
      occ_r  <= occ_nxt;
      p0_r   <= p0_nxt;
      p1_r   <= p0_r;
      p2_r   <= p1_r;
      p3_r   <= p2_r;
      p4_r   <= p4_nxt;
      cmp0_r <= cmp0_nxt;
      cmp1_r <= cmp0_r;
      cmp2_r <= cmp1_r;
      cmp3_r <= cmp2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (store) begin
        kx_r    <= pkt_i.x;
        ky_r    <= pkt_i.y;
        kw_r    <= pkt_i.w;
        kh_r    <= pkt_i.h;
        karea_r <= pkt_i.area;
      end
      lox0_r   <= lox0_nxt;
      hix0_r   <= hix0_nxt;
      loy0_r   <= loy0_nxt;
      hiy0_r   <= hiy0_nxt;
      karea0_r <= karea_r;
      ovx1_r   <= ovx1_nxt;
      ovy1_r   <= ovy1_nxt;
      sum1_r   <= sum1_nxt;
      inter2_r <= gbnms_pkg::AREA_W'(ovx1_r) * gbnms_pkg::AREA_W'(ovy1_r);
      ts2_r    <= gbnms_pkg::PROD_W'(thr) * gbnms_pkg::PROD_W'(sum1_r);
      li3_r    <= gbnms_pkg::PROD_W'(inter2_r) *
                  gbnms_pkg::PROD_W'(gbnms_pkg::THR_ONE + (gbnms_pkg::THR_W+1)'(thr));
      ts3_r    <= ts2_r;
    end
  end

  assign pkt_o = p4_r;

`ifndef SYNTHESIS
  a_occ_only_by_store: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(occ_r) |-> $past(adv && store))
    else $error("cell filled without a store");

  a_stored_not_sup: assert property (@(posedge clk) disable iff (!rst_n)
    (pkt_o.vld && pkt_o.stored) |-> !pkt_o.sup)
    else $error("stored box marked suppressed");

  a_store_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && store) |=> occ_r)
    else $error("store did not fill the cell");
`endif

endmodule

// ===== src/greedy_box_nms.sv =====
// an input transaction passes the entry register and then every cell of the row before out_valid
// throughput: one transaction per cycle when not stalled; kept-box cells are each a 5-stage pipe
// the whole row stalls together while a finished result waits on out_ready
// reset: synchronous, active low; clears the pipe valids, the cell fill bits, the frame
// counter, and loads iou_threshold with 29491 (0.45 in Q0.16)
module greedy_box_nms #(
  parameter int MAX_KEPT  = gbnms_pkg::MAX_KEPT_DEF,
  parameter int MAX_ITEMS = gbnms_pkg::MAX_ITEMS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,

  // input channel
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_first_of_frame,
  input  logic signed [gbnms_pkg::COORD_W-1:0]  in_box_x,
  input  logic signed [gbnms_pkg::COORD_W-1:0]  in_box_y,
  input  logic [gbnms_pkg::LEN_W-1:0]           in_box_w,
  input  logic [gbnms_pkg::LEN_W-1:0]           in_box_h,

  // result channel
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_keep,
  output logic [gbnms_pkg::ITEM_IDX_W-1:0]      out_item_index,
  output logic                                  out_overflow,

  // configuration port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [gbnms_pkg::CFG_AW-1:0]          paddr,
  input  logic [gbnms_pkg::CFG_DW-1:0]          pwdata,
  output logic [gbnms_pkg::CFG_DW-1:0]          prdata,
  output logic                                  pready
);

  localparam int CNT_W = $clog2(MAX_ITEMS);

  // iou threshold register
  logic [gbnms_pkg::THR_W-1:0] thr_r;
  logic                        cfg_wr;

  // frame item counter
  logic [CNT_W-1:0]                  cnt_r;
  logic [CNT_W-1:0]                  cnt_nxt;
  logic [CNT_W-1:0]                  idx_cur;
  logic [gbnms_pkg::CNT_MAX_W-1:0]   idx_wide;

  // entry stage and the cell chain
  gbnms_pkg::box_pkt_t ent_r;
  gbnms_pkg::box_pkt_t ent_nxt;
  gbnms_pkg::box_pkt_t chain [0:MAX_KEPT];
  gbnms_pkg::box_pkt_t last;

  logic adv;
  logic in_acc;

  // register reads and writes; the register index is paddr[2], low bits are byte offset
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = (paddr[2] == gbnms_pkg::REG_IOU_THR)
                ? gbnms_pkg::CFG_DW'(thr_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= gbnms_pkg::IOU_THR_RESET;
    end else if (cfg_wr && paddr[2] == gbnms_pkg::REG_IOU_THR) begin
      thr_r <= pwdata[gbnms_pkg::THR_W-1:0];
    end
  end

  // the whole row moves when the output register is empty or being drained
  assign last      = chain[MAX_KEPT];
  assign adv       = ~last.vld | out_ready;
  assign in_ready  = adv;
  assign in_acc    = in_valid & in_ready;

  // index restarts at the first box of a frame and wraps at MAX_ITEMS
  always_comb begin
    idx_cur  = in_first_of_frame ? '0 : cnt_r;
    cnt_nxt  = (idx_cur == CNT_W'(MAX_ITEMS - 1)) ? '0 : idx_cur + 1'b1;
    idx_wide = gbnms_pkg::CNT_MAX_W'(idx_cur);

    ent_nxt        = '0;
    ent_nxt.vld    = in_valid;
    ent_nxt.first  = in_first_of_frame;
    ent_nxt.x      = in_box_x;
    ent_nxt.y      = in_box_y;
    ent_nxt.w      = in_box_w;
    ent_nxt.h      = in_box_h;
    ent_nxt.area   = gbnms_pkg::AREA_W'(in_box_w) * gbnms_pkg::AREA_W'(in_box_h);
    ent_nxt.idx    = idx_wide[gbnms_pkg::ITEM_IDX_W-1:0];
    ent_nxt.sup    = 1'b0;
    ent_nxt.stored = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ent_r <= '0;
    end else begin
      if (in_acc) begin
        cnt_r <= cnt_nxt;
      end
      if (adv) begin
        ent_r <= ent_nxt;
      end
    end
  end

  // each cell holds one kept box; a box takes the first empty cell it reaches
  // unsuppressed, so the cells fill in order and later boxes trail behind
  assign chain[0] = ent_r;

  for (genvar g = 0; g < MAX_KEPT; g++) begin : g_cell
    gbnms_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .thr   (thr_r),
      .pkt_i (chain[g]),
      .pkt_o (chain[g+1])
    );
  end

  // last cell output is the result register; not stored and not suppressed means the row was full
  assign out_valid      = last.vld;
  assign out_keep       = ~last.sup;
  assign out_item_index = last.idx;
  assign out_overflow   = ~last.sup & ~last.stored;

`ifndef SYNTHESIS
  a_ovf_needs_keep: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_keep || !out_overflow))
    else $error("overflow on a suppressed box");

  a_first_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_first_of_frame) |=> (ent_r.idx == '0))
    else $error("first box of frame without index zero");

  a_thr_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr && paddr[2] == gbnms_pkg::REG_IOU_THR) |=>
      (thr_r == $past(pwdata[gbnms_pkg::THR_W-1:0])))
    else $error("threshold write lost");
`endif

endmodule
